// ===== hw/rtl/msp_pkg.sv =====
`timescale 1ns / 1ps

package msp_pkg;

    // Box geometry and field widths
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH + 1);
    localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LABEL_W   = 32;
    localparam int CNT_W     = 21;
    localparam int PERIM_W   = 37;
    localparam int INC_W     = 3;

    // Perimeter weights, 16 fraction bits
    localparam int FRAC_W      = 16;
    localparam int CORNER_WT_W = 16;
    localparam int DIAG_WT_W   = 17;
    localparam logic [CORNER_WT_W-1:0] CORNER_WT = 16'd46341;
    localparam logic [DIAG_WT_W-1:0]   DIAG_WT   = 17'd92682;

    localparam int SUM_W = CNT_W + DIAG_WT_W + 2;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [PERIM_W-1:0] PERIM_MAX = {PERIM_W{1'b1}};

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_CORNER = 2'd1,
        CLS_EDGE   = 2'd2,
        CLS_DIAG   = 2'd3
    } cell_class_t;

    typedef struct packed {
        logic [CNT_W-1:0] area_cnt;
        logic [CNT_W-1:0] edge_cnt;
        logic [CNT_W-1:0] corner_cnt;
        logic [CNT_W-1:0] diag_cnt;
    } box_counts_t;

    // Sort one 2x2 cell by its inside corners
    function automatic cell_class_t classify(input logic ul, input logic ur,
                                             input logic ll, input logic lr);
        logic [2:0] n;
        n = {2'b00, ul} + {2'b00, ur} + {2'b00, ll} + {2'b00, lr};
        if (n == 3'd1 || n == 3'd3)
            return CLS_CORNER;
        else if (n == 3'd2)
            return (ul == lr) ? CLS_DIAG : CLS_EDGE;
        else
            return CLS_NONE;
    endfunction

    // Add a small increment, saturating at the counter maximum
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [INC_W-1:0] k);
        logic [CNT_W:0] s;
        s = {1'b0, v} + {{(CNT_W + 1 - INC_W){1'b0}}, k};
        return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/msp_pixel_if.sv =====
`timescale 1ns / 1ps

interface msp_pixel_if import msp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] pixel_label;
    logic               row_end;
    logic               last_row;

    modport source (output valid, output pixel_label, output row_end, output last_row,
                    input ready);
    modport sink (input valid, input pixel_label, input row_end, input last_row,
                  output ready);
endinterface

// ===== hw/rtl/msp_result_if.sv =====
`timescale 1ns / 1ps

interface msp_result_if import msp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PERIM_W-1:0] perimeter_fixed;
    logic [CNT_W-1:0]   area_count;
    logic [CNT_W-1:0]   edge_cells;
    logic [CNT_W-1:0]   corner_cells;
    logic [CNT_W-1:0]   diagonal_cells;

    modport source (output valid, output perimeter_fixed, output area_count,
                    output edge_cells, output corner_cells, output diagonal_cells,
                    input ready);
    modport sink (input valid, input perimeter_fixed, input area_count,
                  input edge_cells, input corner_cells, input diagonal_cells,
                  output ready);
endinterface

// ===== hw/rtl/msp_cell_stage.sv =====
`timescale 1ns / 1ps

module msp_cell_stage import msp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LABEL_W-1:0] target_label,
    msp_pixel_if.sink          pix,
    output logic               box_valid,
    input  logic               box_ready,
    output box_counts_t        box_counts
);

    // Row buffer of inside bits, registered read
    logic row_mem [MAX_WIDTH];
    logic rd_data_reg;

    // Column tracking at accept time
    logic [COL_W-1:0] col_reg, col_next;
    logic             first_row_reg, first_row_next;

    // Classification stage
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_cur_reg;
    logic              s1_row_end_reg;
    logic              s1_last_row_reg;
    logic              s1_up_ok_reg;
    logic              s1_wr_ok_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              fwd_hit_reg;
    logic              fwd_bit_reg;

    logic             left_reg, left_next;
    logic             ul_reg, ul_next;
    logic [CNT_W-1:0] area_reg, area_next;
    logic [CNT_W-1:0] edge_reg, edge_next;
    logic [CNT_W-1:0] corner_reg, corner_next;
    logic [CNT_W-1:0] diag_reg, diag_next;

    logic              accept;
    logic              col_in_range;
    logic [ADDR_W-1:0] rd_addr;
    logic              s1_final;
    logic              s1_adv;
    logic              mem_we;
    logic              up;
    cell_class_t       cls [4];
    logic [INC_W-1:0]  n_edge, n_corner, n_diag;
    logic [CNT_W-1:0]  area_sum, edge_sum, corner_sum, diag_sum;

    // Handshake and stage advance
    assign s1_final  = s1_row_end_reg && s1_last_row_reg;
    assign s1_adv    = s1_valid_reg && (!s1_final || box_ready);
    assign pix.ready = !s1_valid_reg || s1_adv;
    assign accept    = pix.valid && pix.ready;

    assign col_in_range = col_reg < COL_W'(MAX_WIDTH);
    assign rd_addr      = col_reg[ADDR_W-1:0];
    assign mem_we       = s1_adv && s1_wr_ok_reg;

    // Write back the current bit, read the row above for the next word
    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[s1_addr_reg] <= s1_cur_reg;
        if (accept)
            rd_data_reg <= row_mem[rd_addr];
    end

    // Advance the column and row flags
    always_comb
    begin
        col_next       = col_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if (pix.row_end)
                col_next = '0;
            else if (col_in_range)
                col_next = col_reg + COL_W'(1);
            if (pix.row_end)
                first_row_next = pix.last_row;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            first_row_reg <= first_row_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    // Load the stage payload; forward a write to the same column
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg      <= (pix.pixel_label == target_label);
            s1_row_end_reg  <= pix.row_end;
            s1_last_row_reg <= pix.last_row;
            s1_up_ok_reg    <= !first_row_reg && col_in_range;
            s1_wr_ok_reg    <= col_in_range;
            s1_addr_reg     <= rd_addr;
            fwd_hit_reg     <= mem_we && (s1_addr_reg == rd_addr);
            fwd_bit_reg     <= s1_cur_reg;
        end
    end

    // Classify the cells touched by this pixel
    assign up = s1_up_ok_reg && (fwd_hit_reg ? fwd_bit_reg : rd_data_reg);

    always_comb
    begin
        cls[0] = classify(ul_reg, up, left_reg, s1_cur_reg);
        cls[1] = s1_row_end_reg ? classify(up, 1'b0, s1_cur_reg, 1'b0) : CLS_NONE;
        cls[2] = s1_last_row_reg ? classify(left_reg, s1_cur_reg, 1'b0, 1'b0) : CLS_NONE;
        cls[3] = s1_final ? classify(s1_cur_reg, 1'b0, 1'b0, 1'b0) : CLS_NONE;
    end

    // Count each class among the four cells
    always_comb
    begin
        n_edge   = '0;
        n_corner = '0;
        n_diag   = '0;
        for (int i = 0; i < 4; i++)
        begin
            case (cls[i])
                CLS_CORNER: n_corner = n_corner + INC_W'(1);
                CLS_EDGE:   n_edge   = n_edge + INC_W'(1);
                CLS_DIAG:   n_diag   = n_diag + INC_W'(1);
                default:    ;
            endcase
        end
    end

    assign area_sum   = sat_add(area_reg, {{(INC_W - 1){1'b0}}, s1_cur_reg});
    assign edge_sum   = sat_add(edge_reg, n_edge);
    assign corner_sum = sat_add(corner_reg, n_corner);
    assign diag_sum   = sat_add(diag_reg, n_diag);

    // Hand the finished box to the perimeter pipeline
    assign box_valid             = s1_valid_reg && s1_final;
    assign box_counts.area_cnt   = area_sum;
    assign box_counts.edge_cnt   = edge_sum;
    assign box_counts.corner_cnt = corner_sum;
    assign box_counts.diag_cnt   = diag_sum;

    // Update neighbors and counters; clear neighbors at a row end and counters at the end of a box
    always_comb
    begin
        left_next   = left_reg;
        ul_next     = ul_reg;
        area_next   = area_reg;
        edge_next   = edge_reg;
        corner_next = corner_reg;
        diag_next   = diag_reg;
        if (s1_adv)
        begin
            left_next   = s1_row_end_reg ? 1'b0 : s1_cur_reg;
            ul_next     = s1_row_end_reg ? 1'b0 : up;
            area_next   = s1_final ? '0 : area_sum;
            edge_next   = s1_final ? '0 : edge_sum;
            corner_next = s1_final ? '0 : corner_sum;
            diag_next   = s1_final ? '0 : diag_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= 1'b0;
            ul_reg     <= 1'b0;
            area_reg   <= '0;
            edge_reg   <= '0;
            corner_reg <= '0;
            diag_reg   <= '0;
        end
        else
        begin
            left_reg   <= left_next;
            ul_reg     <= ul_next;
            area_reg   <= area_next;
            edge_reg   <= edge_next;
            corner_reg <= corner_next;
            diag_reg   <= diag_next;
        end
    end

endmodule

// ===== hw/rtl/msp_perim.sv =====
`timescale 1ns / 1ps

module msp_perim import msp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        box_valid,
    output logic        box_ready,
    input  box_counts_t box_counts,
    msp_result_if.source res
);

    localparam int CORNER_P_W = CNT_W + CORNER_WT_W;
    localparam int DIAG_P_W   = CNT_W + DIAG_WT_W;
    localparam int EDGE_P_W   = CNT_W + FRAC_W;

    // Snapshot stage
    logic        r1_valid_reg, r1_valid_next;
    box_counts_t r1_counts_reg;

    // Product stage
    logic                  r2_valid_reg, r2_valid_next;
    box_counts_t           r2_counts_reg;
    logic [CORNER_P_W-1:0] r2_corner_reg;
    logic [DIAG_P_W-1:0]   r2_diag_reg;

    // Output word
    logic               r3_valid_reg, r3_valid_next;
    box_counts_t        r3_counts_reg;
    logic [PERIM_W-1:0] r3_perim_reg;

    logic               adv2, adv3, load1;
    logic [EDGE_P_W-1:0] edge_term;
    logic [SUM_W-1:0]   perim_sum;
    logic [PERIM_W-1:0] perim_sat;

    // Stage advance, from the output back
    assign adv3      = r2_valid_reg && (!r3_valid_reg || res.ready);
    assign adv2      = r1_valid_reg && (!r2_valid_reg || adv3);
    assign box_ready = !r1_valid_reg || adv2;
    assign load1     = box_valid && box_ready;

    always_comb
    begin
        r1_valid_next = load1 ? 1'b1 : (adv2 ? 1'b0 : r1_valid_reg);
        r2_valid_next = adv2 ? 1'b1 : (adv3 ? 1'b0 : r2_valid_reg);
        r3_valid_next = adv3 ? 1'b1 : (res.ready ? 1'b0 : r3_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
        end
        else
        begin
            r1_valid_reg <= r1_valid_next;
            r2_valid_reg <= r2_valid_next;
            r3_valid_reg <= r3_valid_next;
        end
    end

    // Hold the box counts
    always_ff @(posedge clk)
    begin
        if (load1)
            r1_counts_reg <= box_counts;
    end

    // Weight the corner and diagonal counts
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            r2_counts_reg <= r1_counts_reg;
            r2_corner_reg <= {{CORNER_WT_W{1'b0}}, r1_counts_reg.corner_cnt} *
                             {{CNT_W{1'b0}}, CORNER_WT};
            r2_diag_reg   <= {{DIAG_WT_W{1'b0}}, r1_counts_reg.diag_cnt} *
                             {{CNT_W{1'b0}}, DIAG_WT};
        end
    end

    // Sum the weighted counts and saturate
    assign edge_term = {r2_counts_reg.edge_cnt, {FRAC_W{1'b0}}};
    assign perim_sum = {{(SUM_W - EDGE_P_W){1'b0}}, edge_term}
                     + {{(SUM_W - CORNER_P_W){1'b0}}, r2_corner_reg}
                     + {{(SUM_W - DIAG_P_W){1'b0}}, r2_diag_reg};
    assign perim_sat = (perim_sum > {{(SUM_W - PERIM_W){1'b0}}, PERIM_MAX})
                     ? PERIM_MAX : perim_sum[PERIM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            r3_counts_reg <= r2_counts_reg;
            r3_perim_reg  <= perim_sat;
        end
    end

    // Drive the result word
    assign res.valid           = r3_valid_reg;
    assign res.perimeter_fixed = r3_perim_reg;
    assign res.area_count      = r3_counts_reg.area_cnt;
    assign res.edge_cells      = r3_counts_reg.edge_cnt;
    assign res.corner_cells    = r3_counts_reg.corner_cnt;
    assign res.diagonal_cells  = r3_counts_reg.diag_cnt;

endmodule

// ===== hw/rtl/marching_squares_perimeter_top.sv =====
// Throughput: one pixel word per cycle; a stall arises only when a result word is held
// by the sink while the three-deep result pipeline is full.
// The result word of a box passes the classification, snapshot, product and output registers after its last pixel.
// Reset (rst_n, async, active low) clears the counters, column state and target label;
// the row buffer holds no valid contents until each column is first written.
`timescale 1ns / 1ps

module marching_squares_perimeter_top import msp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LABEL_W-1:0] cfg_wr_data,
    msp_pixel_if.sink          pix,
    msp_result_if.source       res
);

    logic [LABEL_W-1:0] target_label_reg, target_label_next;
    logic               box_valid;
    logic               box_ready;
    box_counts_t        box_counts;

    // Hold the target label
    assign target_label_next = cfg_wr_en ? cfg_wr_data : target_label_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            target_label_reg <= '0;
        else
            target_label_reg <= target_label_next;
    end

    msp_cell_stage u_cell_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_label (target_label_reg),
        .pix          (pix),
        .box_valid    (box_valid),
        .box_ready    (box_ready),
        .box_counts   (box_counts)
    );

    msp_perim u_perim (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_valid  (box_valid),
        .box_ready  (box_ready),
        .box_counts (box_counts),
        .res        (res)
    );

endmodule
